### src/gfdf_pkg.sv
// gfdf_pkg: shared types, scale tables and the digit step function
// of the fix formatter pipeline
// depends on nothing
package gfdf_pkg;

    // pipeline depth, stage 0 takes the input transaction
    localparam int NSTAGE = 9;

    // first altitude stage that holds the binary feet value
    localparam int ALT_FIRST = 2;

    // largest quotient a single digit step can return
    localparam int DIV_QMAX = 18;

    // per-stage divisors, entry s is applied while loading stage s
    localparam logic [31:0] LAT_SCALE [NSTAGE] = '{
        32'd1, 32'd119304648, 32'd11930465, 32'd1988411, 32'd198842,
        32'd19885, 32'd1989, 32'd1, 32'd1
    };
    localparam logic [NSTAGE-1:0] LAT_DIGIT = 9'b001111110;

    localparam logic [31:0] LON_SCALE [NSTAGE] = '{
        32'd1, 32'd1193046471, 32'd119304647, 32'd11930465, 32'd1988411,
        32'd198842, 32'd19885, 32'd1989, 32'd1
    };
    localparam logic [NSTAGE-1:0] LON_DIGIT = 9'b011111110;

    // decimal divisors for the feet digits, most significant first
    localparam int ALT_DIGITS = NSTAGE - ALT_FIRST - 1;
    localparam logic [31:0] ALT_SCALE [ALT_DIGITS] = '{
        32'd100000, 32'd10000, 32'd1000, 32'd100, 32'd10, 32'd1
    };

    // feet = (mm/4*5)/381 via reciprocal 2^37/381 rounded up
    localparam logic [28:0] ALT_RECIP     = 29'd360732162;
    localparam int          ALT_SHIFT     = 37;
    localparam logic [31:0] ALT_SAT_LIMIT = 32'd381000000;
    localparam logic [19:0] ALT_MAX       = 20'd999999;

    localparam logic [31:0] SIGN_BIT = 32'h8000_0000;

    // load enables, one per pipeline stage
    typedef struct packed {
        logic [NSTAGE-1:0] load;
    } pipe_ctl_t;

    typedef struct packed {
        logic [4:0]  q;
        logic [31:0] rem;
    } dstep_t;

    // one truncating division step by a constant, quotient below DIV_QMAX+1
    function automatic dstep_t div_step(input logic [31:0] rem, input logic [31:0] scale);
        dstep_t      r;
        logic [36:0] mult;
        logic [36:0] sub;
        r.q  = '0;
        sub  = '0;
        for (int k = 1; k <= DIV_QMAX; k++) begin
            mult = 37'(k) * {5'b0, scale};
            if ({5'b0, rem} >= mult) begin
                r.q = 5'(k);
                sub = mult;
            end
        end
        r.rem = rem - sub[31:0];
        return r;
    endfunction

endpackage

### src/gfdf_ctl.sv
// gfdf_ctl: valid bits and backpressure chain of the pipeline
// depends on gfdf_pkg
module gfdf_ctl
    import gfdf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output pipe_ctl_t ctl
);

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE-1:0] rdy;

    // a stage loads when it is empty or its contents move on
    always_comb begin
        rdy[NSTAGE-1] = !valid_reg[NSTAGE-1] || out_ready;
        for (int s = NSTAGE - 2; s >= 0; s--) begin
            rdy[s] = !valid_reg[s] || rdy[s+1];
        end
    end

    // valid bits follow the data
    always_comb begin
        valid_next[0] = rdy[0] ? in_valid : valid_reg[0];
        for (int s = 1; s < NSTAGE; s++) begin
            valid_next[s] = rdy[s] ? valid_reg[s-1] : valid_reg[s];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign ctl.load  = rdy;
    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[NSTAGE-1];

endmodule

### src/gfdf_pos.sv
// gfdf_pos: latitude and longitude sign handling and digit stages
// depends on gfdf_pkg
module gfdf_pos
    import gfdf_pkg::*;
(
    input  logic        aclk,
    input  pipe_ctl_t   ctl,
    input  logic        fix_ok_in,
    input  logic [31:0] lat_in,
    input  logic [31:0] lon_in,
    output logic        fix_ok,
    output logic [23:0] lat_bcd,
    output logic        lat_south,
    output logic [27:0] lon_bcd,
    output logic        lon_west
);

    logic        ok_reg    [NSTAGE];
    logic        south_reg [NSTAGE];
    logic        west_reg  [NSTAGE];
    logic [31:0] lat_rem_reg [NSTAGE];
    logic [23:0] lat_bcd_reg [NSTAGE];
    logic [31:0] lon_rem_reg [NSTAGE];
    logic [27:0] lon_bcd_reg [NSTAGE];

    logic [31:0] lat_rem_next [NSTAGE];
    logic [23:0] lat_bcd_next [NSTAGE];
    logic [31:0] lon_rem_next [NSTAGE];
    logic [27:0] lon_bcd_next [NSTAGE];

    logic        south0;
    logic        west0;
    dstep_t      lat_d [NSTAGE];
    dstep_t      lon_d [NSTAGE];

    // stage 0: hemisphere flags and magnitudes, zero latitude counts as south
    assign south0 = lat_in[31] || (lat_in == '0);
    assign west0  = (lon_in & SIGN_BIT) != '0;

    always_comb begin
        lat_rem_next[0] = '0;
        lon_rem_next[0] = '0;
        lat_bcd_next[0] = '0;
        lon_bcd_next[0] = '0;
        lat_d[0]        = '0;
        lon_d[0]        = '0;
        if (fix_ok_in) begin
            lat_rem_next[0] = south0 ? (32'd0 - lat_in) : lat_in;
            lon_rem_next[0] = west0 ? (32'd0 - lon_in) : lon_in;
        end
        // at most one digit per stage on each coordinate, in the stages that LAT_DIGIT and LON_DIGIT mark
        for (int s = 1; s < NSTAGE; s++) begin
            lat_d[s] = div_step(lat_rem_reg[s-1], LAT_SCALE[s]);
            lon_d[s] = div_step(lon_rem_reg[s-1], LON_SCALE[s]);
            if (LAT_DIGIT[s]) begin
                lat_rem_next[s] = lat_d[s].rem;
                lat_bcd_next[s] = {lat_bcd_reg[s-1][19:0], lat_d[s].q[3:0]};
            end else begin
                lat_rem_next[s] = lat_rem_reg[s-1];
                lat_bcd_next[s] = lat_bcd_reg[s-1];
            end
            if (LON_DIGIT[s]) begin
                lon_rem_next[s] = lon_d[s].rem;
                lon_bcd_next[s] = {lon_bcd_reg[s-1][23:0], lon_d[s].q[3:0]};
            end else begin
                lon_rem_next[s] = lon_rem_reg[s-1];
                lon_bcd_next[s] = lon_bcd_reg[s-1];
            end
        end
    end

    // stage registers
    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            ok_reg[0]    <= fix_ok_in;
            south_reg[0] <= fix_ok_in && south0;
            west_reg[0]  <= fix_ok_in && west0;
        end
        for (int s = 1; s < NSTAGE; s++) begin
            if (ctl.load[s]) begin
                ok_reg[s]    <= ok_reg[s-1];
                south_reg[s] <= south_reg[s-1];
                west_reg[s]  <= west_reg[s-1];
            end
        end
        for (int s = 0; s < NSTAGE; s++) begin
            if (ctl.load[s]) begin
                lat_rem_reg[s] <= lat_rem_next[s];
                lat_bcd_reg[s] <= lat_bcd_next[s];
                lon_rem_reg[s] <= lon_rem_next[s];
                lon_bcd_reg[s] <= lon_bcd_next[s];
            end
        end
    end

    assign fix_ok    = ok_reg[NSTAGE-1];
    assign lat_bcd   = lat_bcd_reg[NSTAGE-1];
    assign lat_south = south_reg[NSTAGE-1];
    assign lon_bcd   = lon_bcd_reg[NSTAGE-1];
    assign lon_west  = west_reg[NSTAGE-1];

endmodule

### src/gfdf_alt.sv
// gfdf_alt: altitude millimetres to clamped feet and six bcd digits
// depends on gfdf_pkg
module gfdf_alt
    import gfdf_pkg::*;
(
    input  logic        aclk,
    input  pipe_ctl_t   ctl,
    input  logic        fix_ok_in,
    input  logic [31:0] alt_in,
    output logic [23:0] alt_bcd
);

    logic [28:0] quarter;
    logic [31:0] n5_next;
    logic [31:0] n5_reg;
    logic        neg0_reg;
    logic [60:0] prod;
    logic [19:0] prod_hi_reg;
    logic        sat_reg;
    logic        neg1_reg;
    logic [19:0] ft;

    logic [19:0] rem_reg  [ALT_FIRST:NSTAGE-1];
    logic [23:0] bcd_reg  [ALT_FIRST:NSTAGE-1];
    logic [19:0] rem_next [ALT_FIRST:NSTAGE-1];
    logic [23:0] bcd_next [ALT_FIRST:NSTAGE-1];
    dstep_t      d        [ALT_FIRST:NSTAGE-1];

    // stage 0: quarter of a non-negative value, times five
    assign quarter = alt_in[30:2];
    assign n5_next = {3'b0, quarter} + {1'b0, quarter, 2'b00};

    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            n5_reg   <= n5_next;
            neg0_reg <= !fix_ok_in || alt_in[31];
        end
    end

    // stage 1: reciprocal multiply for the division by 381, saturation check
    assign prod = 61'(n5_reg) * 61'(ALT_RECIP);

    always_ff @(posedge aclk) begin
        if (ctl.load[1]) begin
            prod_hi_reg <= prod[ALT_SHIFT+19:ALT_SHIFT];
            sat_reg     <= n5_reg >= ALT_SAT_LIMIT;
            neg1_reg    <= neg0_reg;
        end
    end

    // stage 2: clamp to 0..999999
    assign ft = neg1_reg ? 20'd0 : (sat_reg ? ALT_MAX : prod_hi_reg);

    // stages after: one decimal digit each
    always_comb begin
        rem_next[ALT_FIRST] = ft;
        bcd_next[ALT_FIRST] = '0;
        d[ALT_FIRST]        = '0;
        for (int s = ALT_FIRST + 1; s < NSTAGE; s++) begin
            d[s]        = div_step({12'b0, rem_reg[s-1]}, ALT_SCALE[s-ALT_FIRST-1]);
            rem_next[s] = d[s].rem[19:0];
            bcd_next[s] = {bcd_reg[s-1][19:0], d[s].q[3:0]};
        end
    end

    always_ff @(posedge aclk) begin
        for (int s = ALT_FIRST; s < NSTAGE; s++) begin
            if (ctl.load[s]) begin
                rem_reg[s] <= rem_next[s];
                bcd_reg[s] <= bcd_next[s];
            end
        end
    end

    assign alt_bcd = bcd_reg[NSTAGE-1];

endmodule

### src/gps_fix_to_ddmm_formatter_core.sv
// gps_fix_to_ddmm_formatter_core: top level, gps fix to bcd position and altitude
// depends on gfdf_pkg, gfdf_ctl, gfdf_pos, gfdf_alt
//
// channel | ports               | tdata fields, lowest bit first
// --------+---------------------+----------------------------------------------
// input   | s_tvalid/s_tready   | fix_flags 8, lat 32, lon 32, alt_mm 32
// result  | m_tvalid/m_tready   | fix_ok, lat_bcd, lat_south, lon_bcd,
//         |                     | lon_west, alt_bcd, one pad bit
//
// nine register stages: a fix passes through every one of them on its way to the result
// side, and one transaction is taken every cycle while results drain.
// the depth is set by the altitude path, its times-five, multiply and clamp
// stages ahead of its six decimal digit stages; longitude uses seven digit stages.
// a full stage holds its data while the next one cannot load, so a stall on m_tready
// backs up stage by stage and s_tready drops only when every stage is full.
// reset (aresetn low at a clock edge) empties the pipeline; data is not cleared.
module gps_fix_to_ddmm_formatter_core
    import gfdf_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [7:0] fix_flags, [39:8] lat_semicircles, [71:40] lon_semicircles,
    // [103:72] alt_mm
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [0] fix_ok, [24:1] lat_bcd, [25] lat_south, [53:26] lon_bcd,
    // [54] lon_west, [78:55] alt_bcd, [79] zero
    output logic [79:0]  m_tdata
);

    pipe_ctl_t   ctl;
    logic        fix_ok_in;
    logic        fix_ok;
    logic [23:0] lat_bcd;
    logic        lat_south;
    logic [27:0] lon_bcd;
    logic        lon_west;
    logic [23:0] alt_bcd;

    // 3d fix when flag bits 0 and 2 are clear
    assign fix_ok_in = !s_tdata[0] && !s_tdata[2];

    gfdf_ctl u_ctl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .ctl       (ctl)
    );

    gfdf_pos u_pos (
        .aclk      (aclk),
        .ctl       (ctl),
        .fix_ok_in (fix_ok_in),
        .lat_in    (s_tdata[39:8]),
        .lon_in    (s_tdata[71:40]),
        .fix_ok    (fix_ok),
        .lat_bcd   (lat_bcd),
        .lat_south (lat_south),
        .lon_bcd   (lon_bcd),
        .lon_west  (lon_west)
    );

    gfdf_alt u_alt (
        .aclk      (aclk),
        .ctl       (ctl),
        .fix_ok_in (fix_ok_in),
        .alt_in    (s_tdata[103:72]),
        .alt_bcd   (alt_bcd)
    );

    // result packing
    assign m_tdata = {1'b0, alt_bcd, lon_west, lon_bcd, lat_south, lat_bcd, fix_ok};

endmodule

### src/gfdf_checker.sv
// gfdf_checker: port level assertions for the fix formatter, bound to the top
// depends on gps_fix_to_ddmm_formatter_core
module gfdf_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [103:0] s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [79:0]  m_tdata
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // no fix gives an all-zero result
    a_nofix_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[79:1] == '0)
        else $error("fields set without a fix");

    // altitude digits are always decimal
    a_alt_decimal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[58:55] <= 4'd9) && (m_tdata[62:59] <= 4'd9) &&
                     (m_tdata[66:63] <= 4'd9) && (m_tdata[70:67] <= 4'd9) &&
                     (m_tdata[74:71] <= 4'd9) && (m_tdata[78:75] <= 4'd9))
        else $error("altitude digit out of range");

    // the pad bit stays clear
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[79])
        else $error("pad bit set");

endmodule

bind gps_fix_to_ddmm_formatter_core gfdf_checker u_gfdf_checker (.*);
